/* rtl/lir_pkg.sv */
// Package for the line interpolation rasteriser: word types, direction codes,
// the classified line command and the walk-engine state type.
// No dependencies; every other file in rtl/ imports it.
package lir_pkg;

  // Width of every coordinate field on the ports.
  localparam int unsigned COORD_W = 6;

  // Defaults handed to the top-level parameters.
  localparam int unsigned COORD_BITS_DEF = 6;
  localparam int unsigned CMD_DEPTH_DEF  = 2;

  typedef enum logic [1:0] {
    REQ_X_UP   = 2'd0,
    REQ_X_DOWN = 2'd1,
    REQ_Y_DOWN = 2'd2,
    REQ_Y_UP   = 2'd3
  } req_type_e;

  typedef logic [COORD_W-1:0] coord_t;

  // Input word: one line request.
  typedef struct packed {
    req_type_e req_type;
    coord_t    start_x;
    coord_t    start_y;
    coord_t    end_x;
    coord_t    end_y;
  } line_req_t;

  // Output word: one plotted pixel.
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } pixel_t;

  // Classified line, as queued between the front end and the walk engine.
  typedef struct packed {
    logic   along_x;
    logic   upward;
    logic   minor_neg;
    coord_t s_major;
    coord_t s_minor;
    coord_t span;
    coord_t d_minor_abs;
  } line_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_WALK
  } back_state_e;

endpackage

/* rtl/lir_front.sv */
// Front end of the line interpolation rasteriser: holds one request word and
// classifies it into a line command. Depends on lir_pkg.
module lir_front #(
  parameter int unsigned COORD_BITS = lir_pkg::COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lir_pkg::line_req_t in_word_i,
  output logic               cmd_valid_o,
  input  logic               cmd_full_i,
  output lir_pkg::line_cmd_t cmd_o
);
  import lir_pkg::*;

  logic                  hold_valid_q, hold_valid_d;
  line_req_t             hold_q;
  logic                  hold_free;
  logic                  along_x, upward, drop;
  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [COORD_BITS-1:0] s_major, e_major, s_minor, e_minor;

  assign sx = hold_q.start_x[COORD_BITS-1:0];
  assign sy = hold_q.start_y[COORD_BITS-1:0];
  assign ex = hold_q.end_x[COORD_BITS-1:0];
  assign ey = hold_q.end_y[COORD_BITS-1:0];

  always_comb begin
    unique case (hold_q.req_type)
      REQ_X_UP:   begin along_x = 1'b1; upward = 1'b1; end
      REQ_X_DOWN: begin along_x = 1'b1; upward = 1'b0; end
      REQ_Y_DOWN: begin along_x = 1'b0; upward = 1'b0; end
      REQ_Y_UP:   begin along_x = 1'b0; upward = 1'b1; end
      default:    begin along_x = 1'b1; upward = 1'b1; end
    endcase
  end

  assign s_major = along_x ? sx : sy;
  assign e_major = along_x ? ex : ey;
  assign s_minor = along_x ? sy : sx;
  assign e_minor = along_x ? ey : ex;

  // A start lying beyond the end in the walking direction draws nothing.
  assign drop = upward ? (s_major > e_major) : (s_major < e_major);

  always_comb begin
    cmd_o             = '0;
    cmd_o.along_x     = along_x;
    cmd_o.upward      = upward;
    cmd_o.minor_neg   = (e_minor < s_minor);
    cmd_o.s_major     = coord_t'(s_major);
    cmd_o.s_minor     = coord_t'(s_minor);
    cmd_o.span        = coord_t'(upward ? (e_major - s_major) : (s_major - e_major));
    cmd_o.d_minor_abs = coord_t'((e_minor < s_minor) ? (s_minor - e_minor)
                                                     : (e_minor - s_minor));
  end

  assign cmd_valid_o = hold_valid_q && !drop;
  assign hold_free   = !hold_valid_q || drop || !cmd_full_i;
  assign in_stall_o  = !hold_free;
  assign hold_valid_d = hold_free ? in_valid_i : hold_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && hold_free) begin
      hold_q <= in_word_i;
    end
  end

endmodule

/* rtl/lir_cmd_fifo.sv */
// Short command queue between the front end and the walk engine.
// Depends on lir_pkg for the command type.
module lir_cmd_fifo #(
  parameter int unsigned DEPTH = lir_pkg::CMD_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lir_pkg::line_cmd_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output lir_pkg::line_cmd_t data_o
);
  import lir_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  line_cmd_t        slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/lir_back.sv */
// Walk engine of the line interpolation rasteriser (depends on lir_pkg): a restoring
// divider for the per-step slope, then a stepper: a pixel word a cycle unless stalled.
module lir_back #(
  parameter int unsigned COORD_BITS = lir_pkg::COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  input  lir_pkg::line_cmd_t cmd_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lir_pkg::pixel_t    out_word_o
);
  import lir_pkg::*;

  localparam int unsigned W     = COORD_BITS;
  localparam int unsigned CNT_W = $clog2(COORD_BITS);

  back_state_e    state_q, state_d;
  logic           out_valid_q, out_valid_d;
  pixel_t         out_word_q, out_word_d;
  logic           along_x_q, upward_q, minor_neg_q;
  logic [W-1:0]   s_minor_q, span_q;
  logic [W-1:0]   pos_q, pos_d, left_q, left_d;
  logic [W-1:0]   div_rem_q, div_rem_d, div_quo_q, div_quo_d;
  logic [CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [W-1:0]   acc_q, acc_d, frac_q, frac_d;
  logic           load, emit;

  logic [W:0]     span_ext, shifted, rsum;
  logic           div_ge, wrap;
  logic [W-1:0]   minor, pix_x, pix_y;

  assign span_ext = {1'b0, span_q};
  assign shifted  = {div_rem_q, div_quo_q[W-1]};
  assign div_ge   = (shifted >= span_ext);
  assign rsum     = {1'b0, frac_q} + {1'b0, div_rem_q};
  assign wrap     = (rsum >= span_ext);
  assign minor    = minor_neg_q ? (s_minor_q - acc_q) : (s_minor_q + acc_q);
  assign pix_x    = along_x_q ? pos_q : minor;
  assign pix_y    = along_x_q ? minor : pos_q;

  always_comb begin
    state_d   = state_q;
    load      = 1'b0;
    emit      = 1'b0;
    pos_d     = pos_q;
    left_d    = left_q;
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    div_cnt_d = div_cnt_q;
    acc_d     = acc_q;
    frac_d    = frac_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          load      = 1'b1;
          pos_d     = cmd_i.s_major[W-1:0];
          left_d    = cmd_i.span[W-1:0];
          acc_d     = '0;
          frac_d    = '0;
          div_rem_d = '0;
          div_cnt_d = '0;
          if (cmd_i.span[W-1:0] == '0) begin
            div_quo_d = '0;
            state_d   = BK_WALK;
          end else begin
            div_quo_d = cmd_i.d_minor_abs[W-1:0];
            state_d   = BK_DIVIDE;
          end
        end
      end
      BK_DIVIDE: begin
        div_rem_d = W'(div_ge ? (shifted - span_ext) : shifted);
        div_quo_d = {div_quo_q[W-2:0], div_ge};
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == CNT_W'(W - 1)) begin
          state_d = BK_WALK;
        end
      end
      BK_WALK: begin
        if (!out_valid_q || !out_stall_i) begin
          emit   = 1'b1;
          pos_d  = upward_q ? (pos_q + 1'b1) : (pos_q - 1'b1);
          left_d = left_q - 1'b1;
          frac_d = W'(wrap ? (rsum - span_ext) : rsum);
          acc_d  = acc_q + div_quo_q + W'(wrap);
          if (left_q == '0) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign cmd_pop_o   = load;
  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_comb begin
    out_word_d            = out_word_q;
    if (emit) begin
      out_word_d.pixel_x    = coord_t'(pix_x);
      out_word_d.pixel_y    = coord_t'(pix_y);
      out_word_d.last_pixel = (left_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    pos_q      <= pos_d;
    left_q     <= left_d;
    div_rem_q  <= div_rem_d;
    div_quo_q  <= div_quo_d;
    div_cnt_q  <= div_cnt_d;
    acc_q      <= acc_d;
    frac_q     <= frac_d;
    if (load) begin
      along_x_q   <= cmd_i.along_x;
      upward_q    <= cmd_i.upward;
      minor_neg_q <= cmd_i.minor_neg;
      s_minor_q   <= cmd_i.s_minor[W-1:0];
      span_q      <= cmd_i.span[W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* rtl/line_interpolation_rasterizer_core.sv */
// Top level of the line interpolation rasteriser: front end, command queue and
// walk engine. Depends on lir_pkg, lir_front, lir_cmd_fifo and lir_back.
//
//   Channel | Direction | Word type  | Handshake
//   --------+-----------+------------+---------------------------------------
//   in      | input     | line_req_t | in_valid_i / in_stall_o / in_word_i
//   out     | output    | pixel_t    | out_valid_o / out_stall_i / out_word_o
//
// A line of N+1 pixels (N the major span) occupies the walk engine while it takes
// the command, runs the restoring divider and emits one pixel per cycle while the
// output is not stalled; a zero span skips the divider.
// The front end keeps taking request words during a walk until queue and hold register fill.
// Reset is asynchronous and active low; it empties the queue and the output register.
// A stalled output simply holds the walk; a full queue stalls the input.
module line_interpolation_rasterizer_core #(
  parameter int unsigned COORD_BITS = lir_pkg::COORD_BITS_DEF,
  parameter int unsigned CMD_DEPTH  = lir_pkg::CMD_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lir_pkg::line_req_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lir_pkg::pixel_t    out_word_o
);
  import lir_pkg::*;

  // Classified commands flow from the front end through the queue to the walk engine.
  line_cmd_t front_cmd, queue_cmd;
  logic      front_valid, queue_full, queue_empty, back_pop;

  // The front end registers each request word, works out the major axis, the
  // walking direction and both spans, and drops lines that draw nothing.
  lir_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (front_valid),
    .cmd_full_i  (queue_full),
    .cmd_o       (front_cmd)
  );

  // The queue lets the front end carry on while the walk engine is held up.
  lir_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .empty_o (queue_empty),
    .data_o  (queue_cmd)
  );

  // The walk engine divides the minor span by the major span once, then steps
  // the quotient and remainder to give each pixel's minor coordinate exactly.
  lir_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!queue_empty),
    .cmd_pop_o   (back_pop),
    .cmd_i       (queue_cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* rtl/lir_checker.sv */
// Port-level checks for the line interpolation rasteriser, bound to the top level.
// Depends on lir_pkg and line_interpolation_rasterizer_core.
module lir_checker #(
  parameter int unsigned COORD_BITS = lir_pkg::COORD_BITS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input lir_pkg::line_req_t in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lir_pkg::pixel_t    out_word_o
);
  import lir_pkg::*;

  logic out_taken;

  assign out_taken = out_valid_o && !out_stall_i;

  // A stalled request word is held unchanged by the sender.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("stalled request word changed");

  // A stalled output word is held unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // Pixels of one line follow each other without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_taken && !out_word_o.last_pixel |=> out_valid_o)
    else $error("gap inside a line");

  // Consecutive pixels of one line move by one along an axis.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_taken && !out_word_o.last_pixel |=>
      (out_word_o.pixel_x == ($past(out_word_o.pixel_x) + coord_t'(1))) ||
      ($past(out_word_o.pixel_x) == (out_word_o.pixel_x + coord_t'(1))) ||
      (out_word_o.pixel_y == ($past(out_word_o.pixel_y) + coord_t'(1))) ||
      ($past(out_word_o.pixel_y) == (out_word_o.pixel_y + coord_t'(1))))
    else $error("major coordinate did not step by one");

  // Plotted coordinates stay within the configured coordinate width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_word_o.pixel_x >> COORD_BITS) == '0) &&
                    ((out_word_o.pixel_y >> COORD_BITS) == '0))
    else $error("pixel coordinate out of range");

endmodule

bind line_interpolation_rasterizer_core lir_checker #(
  .COORD_BITS (COORD_BITS)
) u_lir_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
